// ----- src/nec_ir_frame_decoder_top_defines.svh -----
// assertion helpers for the nec ir frame decoder checker
`ifndef NEC_IR_FRAME_DECODER_TOP_DEFINES_SVH
`define NEC_IR_FRAME_DECODER_TOP_DEFINES_SVH

// property that holds in the same cycle
`define NEC_IR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// property whose consequent holds in the cycle after the antecedent
`define NEC_IR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/nec_ir_pkg.sv -----
package nec_ir_pkg;

    // frame shape
    localparam int NORMAL_LEN = 34;
    localparam int REPEAT_LEN = 2;
    localparam int ADDR_BITS  = 16;
    localparam int DATA_BITS  = 2 * ADDR_BITS;

    localparam int TICK_W  = 15;
    localparam int TOL_W   = 12;
    localparam int INDEX_W = 3;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_TOLERANCE    = 3'd0;
    localparam logic [INDEX_W-1:0] REG_LEADER_MARK  = 3'd1;
    localparam logic [INDEX_W-1:0] REG_LEADER_SPACE = 3'd2;
    localparam logic [INDEX_W-1:0] REG_REPEAT_SPACE = 3'd3;
    localparam logic [INDEX_W-1:0] REG_BIT_MARK     = 3'd4;
    localparam logic [INDEX_W-1:0] REG_ZERO_SPACE   = 3'd5;
    localparam logic [INDEX_W-1:0] REG_ONE_SPACE    = 3'd6;

    // register reset values
    localparam logic [TOL_W-1:0]  RST_TOLERANCE    = 12'd200;
    localparam logic [TICK_W-1:0] RST_LEADER_MARK  = 15'd9000;
    localparam logic [TICK_W-1:0] RST_LEADER_SPACE = 15'd4500;
    localparam logic [TICK_W-1:0] RST_REPEAT_SPACE = 15'd2250;
    localparam logic [TICK_W-1:0] RST_BIT_MARK     = 15'd560;
    localparam logic [TICK_W-1:0] RST_ZERO_SPACE   = 15'd560;
    localparam logic [TICK_W-1:0] RST_ONE_SPACE    = 15'd1690;

    typedef enum logic [2:0] {
        STATUS_NEW     = 3'd0,
        STATUS_REPEAT  = 3'd1,
        STATUS_TIMING  = 3'd2,
        STATUS_LENGTH  = 3'd3,
        STATUS_ZERO    = 3'd4
    } status_t;

    typedef struct packed {
        logic [TOL_W-1:0]  tolerance;
        logic [TICK_W-1:0] leader_mark;
        logic [TICK_W-1:0] leader_space;
        logic [TICK_W-1:0] repeat_space;
        logic [TICK_W-1:0] bit_mark;
        logic [TICK_W-1:0] zero_space;
        logic [TICK_W-1:0] one_space;
    } cfg_t;

    typedef struct packed {
        logic leader_normal;
        logic leader_repeat;
        logic bit_one;
        logic bit_valid;
    } sym_class_t;

endpackage

// ----- src/nec_ir_cfg_regs.sv -----
module nec_ir_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nec_ir_pkg::INDEX_W-1:0]    cfg_index,
    input  logic [nec_ir_pkg::TICK_W-1:0]     cfg_data,
    output nec_ir_pkg::cfg_t                  cfg
);

    nec_ir_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register file, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tolerance    <= nec_ir_pkg::RST_TOLERANCE;
            cfg_reg.leader_mark  <= nec_ir_pkg::RST_LEADER_MARK;
            cfg_reg.leader_space <= nec_ir_pkg::RST_LEADER_SPACE;
            cfg_reg.repeat_space <= nec_ir_pkg::RST_REPEAT_SPACE;
            cfg_reg.bit_mark     <= nec_ir_pkg::RST_BIT_MARK;
            cfg_reg.zero_space   <= nec_ir_pkg::RST_ZERO_SPACE;
            cfg_reg.one_space    <= nec_ir_pkg::RST_ONE_SPACE;
        end else if (cfg_valid) begin
            case (cfg_index)
                nec_ir_pkg::REG_TOLERANCE: begin
                    cfg_reg.tolerance <= cfg_data[nec_ir_pkg::TOL_W-1:0];
                end
                nec_ir_pkg::REG_LEADER_MARK:  cfg_reg.leader_mark  <= cfg_data;
                nec_ir_pkg::REG_LEADER_SPACE: cfg_reg.leader_space <= cfg_data;
                nec_ir_pkg::REG_REPEAT_SPACE: cfg_reg.repeat_space <= cfg_data;
                nec_ir_pkg::REG_BIT_MARK:     cfg_reg.bit_mark     <= cfg_data;
                nec_ir_pkg::REG_ZERO_SPACE:   cfg_reg.zero_space   <= cfg_data;
                nec_ir_pkg::REG_ONE_SPACE:    cfg_reg.one_space    <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ----- src/nec_ir_sym_class.sv -----
module nec_ir_sym_class (
    input  logic [nec_ir_pkg::TICK_W-1:0] mark_ticks,
    input  logic [nec_ir_pkg::TICK_W-1:0] space_ticks,
    input  nec_ir_pkg::cfg_t              cfg,
    output nec_ir_pkg::sym_class_t        cls
);

    // strict window spec-tol < sig < spec+tol, lower side as sig+tol > spec
    function automatic logic near(input logic [nec_ir_pkg::TICK_W-1:0] sig,
                                  input logic [nec_ir_pkg::TICK_W-1:0] spec,
                                  input logic [nec_ir_pkg::TOL_W-1:0]  tol);
        logic [nec_ir_pkg::TICK_W:0] upper;
        logic [nec_ir_pkg::TICK_W:0] sig_up;
        upper  = {1'b0, spec} + {{(nec_ir_pkg::TICK_W + 1 - nec_ir_pkg::TOL_W){1'b0}}, tol};
        sig_up = {1'b0, sig} + {{(nec_ir_pkg::TICK_W + 1 - nec_ir_pkg::TOL_W){1'b0}}, tol};
        return ({1'b0, sig} < upper) && (sig_up > {1'b0, spec});
    endfunction

    logic lead_mark_ok;
    logic bit_mark_ok;
    logic one_ok;
    logic zero_ok;

    // window tests on the symbol
    always_comb begin
        lead_mark_ok      = near(mark_ticks, cfg.leader_mark, cfg.tolerance);
        bit_mark_ok       = near(mark_ticks, cfg.bit_mark, cfg.tolerance);
        one_ok            = bit_mark_ok && near(space_ticks, cfg.one_space, cfg.tolerance);
        zero_ok           = bit_mark_ok && near(space_ticks, cfg.zero_space, cfg.tolerance);
        cls.leader_normal = lead_mark_ok && near(space_ticks, cfg.leader_space, cfg.tolerance);
        cls.leader_repeat = lead_mark_ok && near(space_ticks, cfg.repeat_space, cfg.tolerance);
        cls.bit_one       = one_ok;
        cls.bit_valid     = one_ok || zero_ok;
    end

endmodule

// ----- src/nec_ir_frame_ctrl.sv -----
module nec_ir_frame_ctrl #(
    parameter int MAX_SYMBOLS = 63
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic                   sym_valid,
    input  logic                   sym_end,
    input  nec_ir_pkg::sym_class_t cls,
    output logic                   out_valid,
    output logic [15:0]            out_address,
    output logic [15:0]            out_command,
    output logic [2:0]             out_status
);

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int DW    = nec_ir_pkg::DATA_BITS;
    localparam int AW    = nec_ir_pkg::ADDR_BITS;

    logic [CNT_W-1:0] count_reg, count_next, count_inc;
    logic [DW-1:0]    shift_reg, shift_next, shift_upd;
    logic             lead_n_reg, lead_n_next, lead_n_upd;
    logic             lead_r_reg, lead_r_next, lead_r_upd;
    logic             bits_ok_reg, bits_ok_next, bits_ok_upd;
    logic [AW-1:0]    saved_addr_reg, saved_addr_next;
    logic [AW-1:0]    saved_cmd_reg, saved_cmd_next;
    logic             out_valid_reg, out_valid_next;
    logic [AW-1:0]    out_addr_reg, out_addr_next;
    logic [AW-1:0]    out_cmd_reg, out_cmd_next;
    nec_ir_pkg::status_t out_status_reg, out_status_next;
    logic             step;

    assign step        = advance && sym_valid;
    assign out_valid   = out_valid_reg;
    assign out_address = out_addr_reg;
    assign out_command = out_cmd_reg;
    assign out_status  = out_status_reg;

    // per-symbol update and frame-end evaluation
    always_comb begin
        lead_n_upd  = lead_n_reg;
        lead_r_upd  = lead_r_reg;
        bits_ok_upd = bits_ok_reg;
        shift_upd   = shift_reg;
        if (count_reg == '0) begin
            lead_n_upd = cls.leader_normal;
            lead_r_upd = cls.leader_repeat;
        end else if (count_reg <= CNT_W'(DW)) begin
            shift_upd   = {cls.bit_one, shift_reg[DW-1:1]};
            bits_ok_upd = bits_ok_reg && cls.bit_valid;
        end
        count_inc = (count_reg < CNT_W'(MAX_SYMBOLS)) ? count_reg + 1'b1 : count_reg;

        count_next      = count_reg;
        shift_next      = shift_reg;
        lead_n_next     = lead_n_reg;
        lead_r_next     = lead_r_reg;
        bits_ok_next    = bits_ok_reg;
        saved_addr_next = saved_addr_reg;
        saved_cmd_next  = saved_cmd_reg;
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_cmd_next    = out_cmd_reg;
        out_status_next = out_status_reg;

        if (advance) begin
            out_valid_next = 1'b0;
        end

        if (step && !sym_end) begin
            count_next   = count_inc;
            shift_next   = shift_upd;
            lead_n_next  = lead_n_upd;
            lead_r_next  = lead_r_upd;
            bits_ok_next = bits_ok_upd;
        end else if (step) begin
            out_valid_next = 1'b1;
            out_addr_next  = saved_addr_reg;
            out_cmd_next   = saved_cmd_reg;
            if (count_inc == CNT_W'(nec_ir_pkg::NORMAL_LEN)) begin
                if (lead_n_upd && bits_ok_upd) begin
                    saved_addr_next = shift_upd[AW-1:0];
                    saved_cmd_next  = shift_upd[DW-1:AW];
                    out_addr_next   = shift_upd[AW-1:0];
                    out_cmd_next    = shift_upd[DW-1:AW];
                    out_status_next = (shift_upd[DW-1:AW] != '0) ?
                                      nec_ir_pkg::STATUS_NEW : nec_ir_pkg::STATUS_ZERO;
                end else begin
                    out_status_next = nec_ir_pkg::STATUS_TIMING;
                end
            end else if (count_inc == CNT_W'(nec_ir_pkg::REPEAT_LEN)) begin
                if (lead_r_upd) begin
                    out_status_next = (saved_cmd_reg != '0) ?
                                      nec_ir_pkg::STATUS_REPEAT : nec_ir_pkg::STATUS_ZERO;
                end else begin
                    out_status_next = nec_ir_pkg::STATUS_TIMING;
                end
            end else begin
                out_status_next = nec_ir_pkg::STATUS_LENGTH;
            end
            // frame state back to idle
            count_next   = '0;
            shift_next   = '0;
            lead_n_next  = 1'b0;
            lead_r_next  = 1'b0;
            bits_ok_next = 1'b1;
        end
    end

    // control and frame state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            shift_reg      <= '0;
            lead_n_reg     <= 1'b0;
            lead_r_reg     <= 1'b0;
            bits_ok_reg    <= 1'b1;
            saved_addr_reg <= '0;
            saved_cmd_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            count_reg      <= count_next;
            shift_reg      <= shift_next;
            lead_n_reg     <= lead_n_next;
            lead_r_reg     <= lead_r_next;
            bits_ok_reg    <= bits_ok_next;
            saved_addr_reg <= saved_addr_next;
            saved_cmd_reg  <= saved_cmd_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        out_addr_reg   <= out_addr_next;
        out_cmd_reg    <= out_cmd_next;
        out_status_reg <= out_status_next;
    end

endmodule

// ----- src/nec_ir_frame_decoder_top.sv -----
// NEC infrared frame decoder. Each s_ transfer carries one symbol (mark and space
// durations in ticks, tlast on the last symbol of a frame). Every frame end yields
// one m_ transfer with address, command and a status code; other symbols yield
// nothing. One symbol is taken every cycle while the output side does not stall:
// a symbol is captured in the input register, the window compares and the bit
// shifter settle on it, and the result is loaded into the output register when
// the pipeline advances, which raises m_tvalid.
// The input side stalls only while the output register holds a result that
// m_tready has not taken. Timing windows are set through the cfg port; it must
// be written while no frame is in flight, which the block itself does not enforce.
module nec_ir_frame_decoder_top #(
    parameter int MAX_SYMBOLS = 63
) (
    input  logic        aclk,
    input  logic        aresetn,
    // symbol input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [14:0] mark_ticks, [29:15] space_ticks, [31:30] zero
    input  logic        s_tlast,   // frame_end
    // frame result
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] address_out, [31:16] command_out
    output logic [2:0]  m_tuser,   // [2:0] frame_status
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    nec_ir_pkg::cfg_t       cfg;
    nec_ir_pkg::sym_class_t cls;

    logic        in_valid_reg;
    logic [14:0] in_mark_reg;
    logic [14:0] in_space_reg;
    logic        in_end_reg;
    logic        advance;
    logic [15:0] res_address;
    logic [15:0] res_command;

    // pipeline moves whenever the result register is free or being drained
    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign m_tdata  = {res_command, res_address};

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s_tvalid) begin
            in_mark_reg  <= s_tdata[14:0];
            in_space_reg <= s_tdata[29:15];
            in_end_reg   <= s_tlast;
        end
    end

    nec_ir_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nec_ir_sym_class u_class (
        .mark_ticks  (in_mark_reg),
        .space_ticks (in_space_reg),
        .cfg         (cfg),
        .cls         (cls)
    );

    nec_ir_frame_ctrl #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .sym_valid   (in_valid_reg),
        .sym_end     (in_end_reg),
        .cls         (cls),
        .out_valid   (m_tvalid),
        .out_address (res_address),
        .out_command (res_command),
        .out_status  (m_tuser)
    );

endmodule

// ----- src/nec_ir_frame_decoder_chk.sv -----
`include "nec_ir_frame_decoder_top_defines.svh"

module nec_ir_frame_decoder_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    logic        stalled;
    logic [34:0] payload;
    logic        known_status;
    logic        loud_status;
    logic        zero_command;

    // helper terms for the properties
    assign stalled      = m_tvalid && !m_tready;
    assign payload      = {m_tuser, m_tdata};
    assign known_status = (m_tuser == nec_ir_pkg::STATUS_NEW) ||
                          (m_tuser == nec_ir_pkg::STATUS_REPEAT) ||
                          (m_tuser == nec_ir_pkg::STATUS_TIMING) ||
                          (m_tuser == nec_ir_pkg::STATUS_LENGTH) ||
                          (m_tuser == nec_ir_pkg::STATUS_ZERO);
    assign loud_status  = (m_tuser == nec_ir_pkg::STATUS_NEW) ||
                          (m_tuser == nec_ir_pkg::STATUS_REPEAT);
    assign zero_command = (m_tdata[31:16] == 16'd0);

    // a stalled result holds its payload
    `NEC_IR_ASSERT_NEXT(a_hold, stalled, m_tvalid && $stable(payload), "stalled result changed")

    // status stays within the defined codes
    `NEC_IR_ASSERT(a_status_code, !m_tvalid || known_status, "undefined status code")

    // a zero command never reports as new or repeat
    `NEC_IR_ASSERT(a_zero_cmd, !(m_tvalid && loud_status && zero_command), "zero command shown")

    // input stalls only behind a waiting result
    `NEC_IR_ASSERT(a_stall_cause, s_tready || stalled, "input stalled without a waiting result")

endmodule

bind nec_ir_frame_decoder_top nec_ir_frame_decoder_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
